// ===== rtl/http_get_request_parser_defines.svh =====
// Assertion macros shared by the parser modules.
`ifndef HTTP_GET_REQUEST_PARSER_DEFINES_SVH
`define HTTP_GET_REQUEST_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define HGP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hgp: same-cycle check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define HGP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hgp: next-cycle check failed");

`endif

// ===== rtl/hgp_pkg.sv =====
// Types, constants and name tables for the GET request parser.
package hgp_pkg;

  localparam int unsigned HGP_QUEUE_DEPTH = 4;

  localparam logic [3:0] METHOD_LEN  = 4'd3;
  localparam logic [3:0] VERSION_LEN = 4'd7;
  localparam int unsigned NUM_HDR    = 3;

  // Header identifiers as they appear on header_id.
  localparam logic [1:0] HDR_RANGE      = 2'd0;
  localparam logic [1:0] HDR_CONNECTION = 2'd1;
  localparam logic [1:0] HDR_IF_MATCH   = 2'd2;

  // Escape progress inside the target.
  localparam logic [1:0] ESC_IDLE = 2'd0;
  localparam logic [1:0] ESC_HI   = 2'd1;
  localparam logic [1:0] ESC_LO   = 2'd2;

  // Character codes.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;

  typedef enum logic [3:0] {
    PH_METHOD   = 4'd0,
    PH_SPACE    = 4'd1,
    PH_SKIP1    = 4'd2,
    PH_TARGET   = 4'd3,
    PH_VERSION  = 4'd4,
    PH_MINOR    = 4'd5,
    PH_CR1      = 4'd6,
    PH_LF1      = 4'd7,
    PH_NAME     = 4'd8,
    PH_BLANKLF  = 4'd9,
    PH_COLON    = 4'd10,
    PH_BLANKS   = 4'd11,
    PH_VALUE    = 4'd12,
    PH_SKIPLINE = 4'd13,
    PH_AFTERCR  = 4'd14
  } phase_e;

  typedef enum logic [1:0] {
    KIND_TARGET    = 2'd0,
    KIND_VALUE     = 2'd1,
    KIND_VALUE_END = 2'd2,
    KIND_VERDICT   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    VERDICT_OK      = 2'd0,
    VERDICT_METHOD  = 2'd1,
    VERDICT_BAD     = 2'd2,
    VERDICT_VERSION = 2'd3
  } verdict_e;

  // One classified input word.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [3:0] nib;
    logic       is_space;
    logic       is_tab;
    logic       is_cr;
    logic       is_lf;
    logic       is_pct;
    logic       is_plus;
    logic       is_colon;
    logic       is_minor;
  } hgp_item_t;

  function automatic logic [7:0] method_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = 8'h47; // G
      4'd1:    c = 8'h45; // E
      4'd2:    c = 8'h54; // T
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] version_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = 8'h48; // H
      4'd1:    c = 8'h54; // T
      4'd2:    c = 8'h54; // T
      4'd3:    c = 8'h50; // P
      4'd4:    c = 8'h2F; // /
      4'd5:    c = 8'h31; // 1
      4'd6:    c = 8'h2E; // .
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [4:0] hdr_len(input logic [1:0] id);
    logic [4:0] n;
    case (id)
      HDR_RANGE:      n = 5'd5;
      HDR_CONNECTION: n = 5'd10;
      HDR_IF_MATCH:   n = 5'd8;
      default:        n = 5'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] hdr_char(input logic [1:0] id, input logic [3:0] pos);
    logic [7:0] c;
    c = 8'h00;
    case (id)
      HDR_RANGE: begin
        case (pos)
          4'd0:    c = 8'h52; // R
          4'd1:    c = 8'h61; // a
          4'd2:    c = 8'h6E; // n
          4'd3:    c = 8'h67; // g
          4'd4:    c = 8'h65; // e
          default: c = 8'h00;
        endcase
      end
      HDR_CONNECTION: begin
        case (pos)
          4'd0:    c = 8'h43; // C
          4'd1:    c = 8'h6F; // o
          4'd2:    c = 8'h6E; // n
          4'd3:    c = 8'h6E; // n
          4'd4:    c = 8'h65; // e
          4'd5:    c = 8'h63; // c
          4'd6:    c = 8'h74; // t
          4'd7:    c = 8'h69; // i
          4'd8:    c = 8'h6F; // o
          4'd9:    c = 8'h6E; // n
          default: c = 8'h00;
        endcase
      end
      HDR_IF_MATCH: begin
        case (pos)
          4'd0:    c = 8'h49; // I
          4'd1:    c = 8'h66; // f
          4'd2:    c = 8'h2D; // -
          4'd3:    c = 8'h4D; // M
          4'd4:    c = 8'h61; // a
          4'd5:    c = 8'h74; // t
          4'd6:    c = 8'h63; // c
          4'd7:    c = 8'h68; // h
          default: c = 8'h00;
        endcase
      end
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/hgp_classify.sv =====
// Front classifier: tags each raw byte with the character classes the parser needs.
module hgp_classify import hgp_pkg::*; (
  input  logic [7:0] data_i,
  input  logic       last_i,
  output hgp_item_t  item_o
);

  logic [7:0] hex_dec;
  logic [7:0] hex_lc;
  logic [7:0] hex_uc;

  assign hex_dec = data_i - 8'h30;
  assign hex_lc  = data_i - 8'h57; // 'a' maps to 10
  assign hex_uc  = data_i - 8'h37; // 'A' maps to 10

  always_comb begin
    item_o          = '0;
    item_o.data     = data_i;
    item_o.last     = last_i;
    item_o.is_space = (data_i == CH_SPACE);
    item_o.is_tab   = (data_i == CH_TAB);
    item_o.is_cr    = (data_i == CH_CR);
    item_o.is_lf    = (data_i == CH_LF);
    item_o.is_pct   = (data_i == CH_PCT);
    item_o.is_plus  = (data_i == CH_PLUS);
    item_o.is_colon = (data_i == CH_COLON);
    item_o.is_minor = (data_i == CH_ZERO) || (data_i == CH_ONE);
    // Anything that is not a hex digit decodes to zero.
    if (data_i >= 8'h30 && data_i <= 8'h39) begin
      item_o.nib = hex_dec[3:0];
    end else if (data_i >= 8'h61 && data_i <= 8'h66) begin
      item_o.nib = hex_lc[3:0];
    end else if (data_i >= 8'h41 && data_i <= 8'h46) begin
      item_o.nib = hex_uc[3:0];
    end else begin
      item_o.nib = 4'h0;
    end
  end

endmodule

// ===== rtl/hgp_queue.sv =====
// Short word queue between the classifier and the parse engine.
`include "http_get_request_parser_defines.svh"
module hgp_queue import hgp_pkg::*; #(
  parameter int unsigned Depth = HGP_QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  hgp_item_t item_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output hgp_item_t item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  hgp_item_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  `HGP_ASSERT_NOW(a_no_pop_empty, pop_i, count_q != '0)
  `HGP_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CntW'(Depth))
  `HGP_ASSERT_NEXT(a_push_grows, push_i && !pop_i, count_q == $past(count_q) + CntW'(1))

endmodule

// ===== rtl/hgp_engine.sv =====
// Back end: request-line and header state machine with a registered result.
`include "http_get_request_parser_defines.svh"
module hgp_engine import hgp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  hgp_item_t  q_item_i,
  output logic       q_pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] kind_o,
  output logic [1:0] header_id_o,
  output logic [7:0] out_byte_o,
  output logic [1:0] verdict_o
);

  phase_e     phase_q, phase_d;
  logic [3:0] pos_q, pos_d;
  logic [2:0] cand_q, cand_d;
  logic [1:0] esc_cnt_q, esc_cnt_d;
  logic [3:0] esc_hi_q, esc_hi_d;
  logic [1:0] match_q, match_d;
  logic       given_q, given_d;

  logic       out_valid_q;
  kind_e      kind_q;
  logic [1:0] hdr_q;
  logic [7:0] byte_q;
  verdict_e   verdict_q;

  logic       res_valid;
  kind_e      res_kind;
  logic [1:0] res_hdr;
  logic [7:0] res_byte;
  verdict_e   res_verdict;

  logic [2:0] keep;
  logic       done;
  logic [1:0] done_id;
  logic       advance;
  logic       pop;
  hgp_item_t  it;

  assign it      = q_item_i;
  assign advance = !out_valid_q || out_ready_i;
  assign pop     = q_valid_i && advance;
  assign q_pop_o = pop;

  // Header name match over the three candidates in parallel.
  always_comb begin
    keep    = '0;
    done    = 1'b0;
    done_id = match_q;
    for (int i = 0; i < NUM_HDR; i++) begin
      if (cand_q[i] && ({1'b0, pos_q} < hdr_len(2'(i)))
          && (hdr_char(2'(i), pos_q) == it.data)) begin
        keep[i] = 1'b1;
        if (!done && (({1'b0, pos_q} + 5'd1) == hdr_len(2'(i)))) begin
          done    = 1'b1;
          done_id = 2'(i);
        end
      end
    end
  end

  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    cand_d      = cand_q;
    esc_cnt_d   = esc_cnt_q;
    esc_hi_d    = esc_hi_q;
    match_d     = match_q;
    given_d     = given_q;
    res_valid   = 1'b0;
    res_kind    = KIND_TARGET;
    res_hdr     = '0;
    res_byte    = '0;
    res_verdict = VERDICT_OK;

    if (!given_q) begin
      case (phase_q)
        PH_METHOD: begin
          if (pos_q >= METHOD_LEN || it.data != method_char(pos_q)) begin
            given_d = 1'b1; res_valid = 1'b1;
            res_kind = KIND_VERDICT; res_verdict = VERDICT_METHOD;
          end else if (pos_q == METHOD_LEN - 4'd1) begin
            phase_d = PH_SPACE;
            pos_d   = '0;
          end else begin
            pos_d = pos_q + 4'd1;
          end
        end
        PH_SPACE: begin
          if (!it.is_space) begin
            given_d = 1'b1; res_valid = 1'b1;
            res_kind = KIND_VERDICT; res_verdict = VERDICT_BAD;
          end else begin
            phase_d = PH_SKIP1;
          end
        end
        PH_SKIP1: begin
          phase_d   = PH_TARGET;
          esc_cnt_d = ESC_IDLE;
        end
        PH_TARGET: begin
          if (it.is_space) begin
            phase_d = PH_VERSION;
            pos_d   = '0;
            // Escape cut short: missing digits count as zero.
            if (esc_cnt_q != ESC_IDLE) begin
              esc_cnt_d = ESC_IDLE;
              res_valid = 1'b1;
              res_byte  = {(esc_cnt_q == ESC_LO) ? esc_hi_q : 4'h0, 4'h0};
            end
          end else if (esc_cnt_q == ESC_HI) begin
            esc_hi_d  = it.nib;
            esc_cnt_d = ESC_LO;
          end else if (esc_cnt_q == ESC_LO) begin
            esc_cnt_d = ESC_IDLE;
            res_valid = 1'b1;
            res_byte  = {esc_hi_q, it.nib};
          end else if (it.is_pct) begin
            esc_cnt_d = ESC_HI;
          end else begin
            res_valid = 1'b1;
            res_byte  = it.is_plus ? CH_SPACE : it.data;
          end
        end
        PH_VERSION: begin
          if (pos_q >= VERSION_LEN || it.data != version_char(pos_q)) begin
            given_d = 1'b1; res_valid = 1'b1;
            res_kind = KIND_VERDICT; res_verdict = VERDICT_BAD;
          end else if (pos_q == VERSION_LEN - 4'd1) begin
            phase_d = PH_MINOR;
            pos_d   = '0;
          end else begin
            pos_d = pos_q + 4'd1;
          end
        end
        PH_MINOR: begin
          if (!it.is_minor) begin
            given_d = 1'b1; res_valid = 1'b1;
            res_kind = KIND_VERDICT; res_verdict = VERDICT_VERSION;
          end else begin
            phase_d = PH_CR1;
          end
        end
        PH_CR1: begin
          if (!it.is_cr) begin
            given_d = 1'b1; res_valid = 1'b1;
            res_kind = KIND_VERDICT; res_verdict = VERDICT_BAD;
          end else begin
            phase_d = PH_LF1;
          end
        end
        PH_LF1: begin
          if (!it.is_lf) begin
            given_d = 1'b1; res_valid = 1'b1;
            res_kind = KIND_VERDICT; res_verdict = VERDICT_BAD;
          end else begin
            phase_d = PH_NAME;
            pos_d   = '0;
            cand_d  = '1;
          end
        end
        PH_NAME: begin
          if (pos_q == 4'd0 && it.is_cr) begin
            phase_d = PH_BLANKLF;
          end else begin
            cand_d = keep;
            if (done) begin
              phase_d = PH_COLON;
              match_d = done_id;
            end else if (keep == '0) begin
              phase_d = it.is_cr ? PH_AFTERCR : PH_SKIPLINE;
            end else begin
              pos_d = pos_q + 4'd1;
            end
          end
        end
        PH_BLANKLF: begin
          if (it.is_lf) begin
            given_d = 1'b1; res_valid = 1'b1;
            res_kind = KIND_VERDICT; res_verdict = VERDICT_OK;
          end else begin
            phase_d = PH_NAME;
            pos_d   = '0;
            cand_d  = '1;
          end
        end
        PH_COLON: begin
          if (!it.is_colon) begin
            given_d = 1'b1; res_valid = 1'b1;
            res_kind = KIND_VERDICT; res_verdict = VERDICT_BAD;
          end else begin
            phase_d = PH_BLANKS;
          end
        end
        PH_BLANKS, PH_VALUE: begin
          // Leading blanks are dropped; the first other byte starts the value.
          if (!(phase_q == PH_BLANKS && (it.is_space || it.is_tab))) begin
            res_valid = 1'b1;
            res_hdr   = match_q;
            if (it.is_cr) begin
              phase_d  = PH_AFTERCR;
              res_kind = KIND_VALUE_END;
            end else begin
              phase_d  = PH_VALUE;
              res_kind = KIND_VALUE;
              res_byte = it.data;
            end
          end
        end
        PH_SKIPLINE: begin
          if (it.is_cr) begin
            phase_d = PH_AFTERCR;
          end
        end
        PH_AFTERCR: begin
          phase_d = PH_NAME;
          pos_d   = '0;
          cand_d  = '1;
        end
        default: begin
          phase_d = phase_q;
        end
      endcase

      // Buffer ran out before a verdict: the error verdict replaces any result.
      if (it.last && !given_d) begin
        res_valid = 1'b1;
        res_kind  = KIND_VERDICT;
        res_hdr   = '0;
        res_byte  = '0;
        if (phase_d == PH_METHOD) begin
          res_verdict = VERDICT_METHOD;
        end else if (phase_d == PH_MINOR) begin
          res_verdict = VERDICT_VERSION;
        end else begin
          res_verdict = VERDICT_BAD;
        end
      end
    end

    if (it.last) begin
      phase_d   = PH_METHOD;
      pos_d     = '0;
      cand_d    = '1;
      esc_cnt_d = ESC_IDLE;
      esc_hi_d  = '0;
      match_d   = '0;
      given_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_METHOD;
      pos_q       <= '0;
      cand_q      <= '1;
      esc_cnt_q   <= ESC_IDLE;
      esc_hi_q    <= '0;
      match_q     <= '0;
      given_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        phase_q   <= phase_d;
        pos_q     <= pos_d;
        cand_q    <= cand_d;
        esc_cnt_q <= esc_cnt_d;
        esc_hi_q  <= esc_hi_d;
        match_q   <= match_d;
        given_q   <= given_d;
      end
      if (advance) begin
        out_valid_q <= pop && res_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && res_valid) begin
      kind_q    <= res_kind;
      hdr_q     <= res_hdr;
      byte_q    <= res_byte;
      verdict_q <= res_verdict;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign header_id_o = hdr_q;
  assign out_byte_o  = byte_q;
  assign verdict_o   = verdict_q;

  `HGP_ASSERT_NOW(a_escape_in_target, esc_cnt_q != ESC_IDLE, phase_q == PH_TARGET)
  `HGP_ASSERT_NEXT(a_last_restarts, pop && it.last, phase_q == PH_METHOD && !given_q && pos_q == '0)
  `HGP_ASSERT_NEXT(a_quiet_after_verdict, pop && given_q, !out_valid_q)
  `HGP_ASSERT_NOW(a_verdict_clean, out_valid_q && kind_q == KIND_VERDICT, byte_q == '0 && hdr_q == '0)

endmodule

// ===== rtl/http_get_request_parser.sv =====
// Top level of the streaming HTTP GET request-line and header parser.
//
// The parser takes one word (a raw request byte plus a buffer-end flag) per
// cycle and, while the output is not stalled, sustains one word per cycle
// with no bubbles: a classifier tags each byte as it is accepted, a short
// queue (QueueDepth words) holds the tagged words, and a parse engine pops
// one word per cycle, while one is queued and its result register is empty
// or being taken, into its state machine and a single result register. A
// byte yields at most one result word: a decoded target byte, a header
// value byte, a header value end, or the verdict. A word is registered in
// the queue and its result in the result register before it is offered;
// an output stall holds the result register, backs up into the queue, and
// in_ready_o drops only once the queue is full. After a verdict the rest
// of the buffer is consumed silently; the word flagged with buffer_end_i
// always returns the parser to its start state, and if no verdict was
// given by then it produces an error verdict.
module http_get_request_parser import hgp_pkg::*; #(
  parameter int unsigned QueueDepth = HGP_QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       buffer_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] kind_o,
  output logic [1:0] header_id_o,
  output logic [7:0] out_byte_o,
  output logic [1:0] verdict_o
);

  hgp_item_t in_item;
  hgp_item_t q_item;
  logic      q_full;
  logic      q_valid;
  logic      q_pop;
  logic      push;

  // Accept while the queue has room.
  assign in_ready_o = !q_full;
  assign push       = in_valid_i && !q_full;

  hgp_classify u_classify (
    .data_i (data_byte_i),
    .last_i (buffer_end_i),
    .item_o (in_item)
  );

  hgp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (in_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  hgp_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .header_id_o (header_id_o),
    .out_byte_o  (out_byte_o),
    .verdict_o   (verdict_o)
  );

endmodule
